/* design/crsm_pkg.sv */
// crsm_pkg: types, widths and constants shared by the color ratio spread mean block
// used by the channel interfaces and all design modules; depends on nothing
package crsm_pkg;

  localparam int unsigned MAX_PAIRS = 65536;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned RATIO_W = 24;
  localparam int unsigned SUMR_W  = 26;
  localparam int unsigned PROD_W  = 52;
  localparam int unsigned T_W     = 54;
  localparam int unsigned ROOT_W  = 26;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned MEAN_W  = 24;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned OPND_W  = 54;
  localparam int unsigned DVSR_W  = 17;
  localparam int unsigned REM_W   = 28;
  localparam int unsigned STEP_W  = 6;

  // pair count stops at the lesser of the set limit and the counter range
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (MAX_PAIRS < 131071) ? COUNT_W'(MAX_PAIRS) : COUNT_W'(131071);

  // divide by three as multiply by ceil(2^28 / 3) and shift, exact for roots below 2^26
  localparam int unsigned        THIRD_SH  = ROOT_W + 2;
  localparam logic [ROOT_W:0]    THIRD_MUL = (ROOT_W+1)'(89478486);

  localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(RATIO_W);
  localparam logic [STEP_W-1:0] ROOT_STEPS  = STEP_W'(ROOT_W);
  localparam logic [STEP_W-1:0] MEAN_STEPS  = STEP_W'(SUM_W);

  typedef enum logic [1:0] {
    UOP_RATIO,
    UOP_ROOT,
    UOP_MEAN
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SUMS,
    ST_DEV,
    ST_MUL,
    ST_ACC,
    ST_RT_GO,
    ST_RT_WAIT,
    ST_SPREAD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [PIX_W-1:0] first_blue;
    logic [PIX_W-1:0] first_green;
    logic [PIX_W-1:0] first_red;
    logic [PIX_W-1:0] second_blue;
    logic [PIX_W-1:0] second_green;
    logic [PIX_W-1:0] second_red;
    logic             last_pair;
  } pair_t;

  typedef struct packed {
    logic       load;
    logic       count_inc;
    logic       unit_start;
    uop_t       uop;
    logic [1:0] ch;
    logic       store_ratio;
    logic       calc_sum;
    logic       dev;
    logic       mul;
    logic       acc;
    logic       store_spread;
    logic       accum;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic capped;
    logic ref_zero;
    logic last;
    logic unit_done;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic              start;
    logic              root_mode;
    logic [OPND_W-1:0] operand;
    logic [DVSR_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } unit_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [OPND_W-1:0] quotient;
    logic [ROOT_W-1:0] root;
  } unit_sts_t;

endpackage

/* design/crsm_if.sv */
// crsm_in_if and crsm_out_if: valid/ready channels for pixel pairs and results
// depends on crsm_pkg for field widths
interface crsm_in_if import crsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] first_blue;
  logic [PIX_W-1:0] first_green;
  logic [PIX_W-1:0] first_red;
  logic [PIX_W-1:0] second_blue;
  logic [PIX_W-1:0] second_green;
  logic [PIX_W-1:0] second_red;
  logic             last_pair;

  modport source (
    output valid, first_blue, first_green, first_red,
           second_blue, second_green, second_red, last_pair,
    input  ready
  );
  modport sink (
    input  valid, first_blue, first_green, first_red,
           second_blue, second_green, second_red, last_pair,
    output ready
  );
endinterface

interface crsm_out_if import crsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  mean_spread;
  logic [COUNT_W-1:0] pair_count;

  modport source (output valid, mean_spread, pair_count, input ready);
  modport sink (input valid, mean_spread, pair_count, output ready);
endinterface

/* design/crsm_divroot.sv */
// crsm_divroot: shared iterative unit, restoring divide one bit a cycle
// or integer square root one bit a cycle; depends on crsm_pkg
module crsm_divroot import crsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  unit_cmd_t cmd,
  output unit_sts_t sts
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic              mode_r;
  logic [OPND_W-1:0] x_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [DVSR_W-1:0] div_r;

  logic [DVSR_W:0]   div_sh;
  logic              div_ge;
  logic [DVSR_W:0]   div_diff;
  logic [REM_W+1:0]  rt_sh;
  logic [REM_W+1:0]  rt_trial;
  logic              rt_ge;
  logic [REM_W+1:0]  rt_diff;

  // divide: bring down one dividend bit
  assign div_sh   = {rem_r[DVSR_W-1:0], x_r[OPND_W-1]};
  assign div_ge   = div_sh >= {1'b0, div_r};
  assign div_diff = div_sh - {1'b0, div_r};

  // root: bring down two bits, trial 4*root+1
  assign rt_sh    = {rem_r, x_r[OPND_W-1 -: 2]};
  assign rt_trial = {2'b00, root_r, 2'b01};
  assign rt_ge    = rt_sh >= rt_trial;
  assign rt_diff  = rt_sh - rt_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r    <= cmd.operand;
      rem_r  <= '0;
      root_r <= '0;
      div_r  <= cmd.divisor;
      mode_r <= cmd.root_mode;
    end else if (busy_r) begin
      if (mode_r) begin
        rem_r  <= rt_ge ? rt_diff[REM_W-1:0] : rt_sh[REM_W-1:0];
        x_r    <= {x_r[OPND_W-3:0], 2'b00};
        root_r <= {root_r[ROOT_W-2:0], rt_ge};
      end else begin
        rem_r <= {(REM_W-DVSR_W)'(0), div_ge ? div_diff[DVSR_W-1:0] : div_sh[DVSR_W-1:0]};
        x_r   <= {x_r[OPND_W-2:0], div_ge};
      end
    end
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = x_r;
  assign sts.root     = root_r;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("divroot started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> busy_r)
    else $error("divroot not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divroot done without finishing a run");
`endif

endmodule

/* design/crsm_datapath.sv */
// crsm_datapath: pair registers, ratio and deviation math, running sum, count,
// output register; holds the shared crsm_divroot unit; depends on crsm_pkg
module crsm_datapath import crsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pair_t              pair,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [MEAN_W-1:0]  out_mean,
  output logic [COUNT_W-1:0] out_count
);

  pair_t              pair_r;
  logic [RATIO_W-1:0] ratio_r [3];
  logic [SUMR_W-1:0]  s_r;
  logic [SUMR_W-1:0]  d_r;
  logic [PROD_W-1:0]  p_r;
  logic [T_W-1:0]     t_r;
  logic [ROOT_W-2:0]  spread_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [COUNT_W-1:0] cnt_r;
  logic               out_valid_r;
  logic [MEAN_W-1:0]  mean_r;
  logic [COUNT_W-1:0] count_r;

  logic [PIX_W-1:0]   num_sel;
  logic [PIX_W-1:0]   den_sel;
  logic [RATIO_W-1:0] ratio_sel;
  logic [SUMR_W-1:0]  three_r;
  logic [2*ROOT_W:0]  third_prod;
  logic [SUM_W:0]     sum_wide;
  logic [MEAN_W-1:0]  mean_nxt;

  unit_cmd_t ucmd;
  unit_sts_t usts;

  crsm_divroot u_divroot (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ucmd),
    .sts   (usts)
  );

  always_comb begin
    case (cmd.ch)
      2'd1: begin
        num_sel   = pair_r.first_green;
        den_sel   = pair_r.second_green;
        ratio_sel = ratio_r[1];
      end
      2'd2: begin
        num_sel   = pair_r.first_red;
        den_sel   = pair_r.second_red;
        ratio_sel = ratio_r[2];
      end
      default: begin
        num_sel   = pair_r.first_blue;
        den_sel   = pair_r.second_blue;
        ratio_sel = ratio_r[0];
      end
    endcase
  end

  always_comb begin
    ucmd.start = cmd.unit_start;
    case (cmd.uop)
      UOP_ROOT: begin
        // deviation sum stays below 2^51, so its top two bits are always zero
        ucmd.root_mode = 1'b1;
        ucmd.operand   = {t_r[T_W-3:0], 2'b00};
        ucmd.divisor   = '0;
        ucmd.steps     = ROOT_STEPS;
      end
      UOP_MEAN: begin
        ucmd.root_mode = 1'b0;
        ucmd.operand   = {sum_r, (OPND_W-SUM_W)'(0)};
        ucmd.divisor   = cnt_r;
        ucmd.steps     = MEAN_STEPS;
      end
      default: begin
        // zero divisor channel taken as one
        ucmd.root_mode = 1'b0;
        ucmd.operand   = {num_sel, 16'h0000, (OPND_W-RATIO_W)'(0)};
        ucmd.divisor   = (den_sel == '0) ? DVSR_W'(1) : DVSR_W'(den_sel);
        ucmd.steps     = RATIO_STEPS;
      end
    endcase
  end

  // floor(sqrt(T/9)) equals floor(floor(sqrt(T)) / 3)
  assign third_prod = usts.root * THIRD_MUL;

  assign three_r  = {1'b0, ratio_sel, 1'b0} + SUMR_W'(ratio_sel);
  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(spread_r);
  assign sum_nxt  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign mean_nxt = (usts.quotient[SUM_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}}
                                                          : usts.quotient[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pair_r <= pair;
    end
    if (cmd.store_ratio) begin
      ratio_r[cmd.ch] <= usts.quotient[RATIO_W-1:0];
    end
    if (cmd.calc_sum) begin
      s_r <= SUMR_W'(ratio_r[0]) + SUMR_W'(ratio_r[1]) + SUMR_W'(ratio_r[2]);
      t_r <= '0;
    end
    if (cmd.dev) begin
      d_r <= (three_r >= s_r) ? (three_r - s_r) : (s_r - three_r);
    end
    if (cmd.mul) begin
      p_r <= d_r * d_r;
    end
    if (cmd.acc) begin
      t_r <= t_r + T_W'(p_r);
    end
    if (cmd.store_spread) begin
      spread_r <= third_prod[2*ROOT_W:THIRD_SH];
    end
    if (cmd.emit) begin
      mean_r  <= mean_nxt;
      count_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.count_inc) begin
        cnt_r <= cnt_r + COUNT_W'(1);
      end
      if (cmd.accum) begin
        sum_r <= sum_nxt;
      end
      if (cmd.emit) begin
        sum_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.capped    = cnt_r >= COUNT_CAP;
  assign sts.ref_zero  = (pair_r.second_blue == '0) && (pair_r.second_green == '0) &&
                         (pair_r.second_red == '0);
  assign sts.last      = pair_r.last_pair;
  assign sts.unit_done = usts.done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_mean  = mean_r;
  assign out_count = count_r;

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (cnt_r == '0) && (sum_r == '0) && out_valid_r)
    else $error("set state not cleared on emit");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || out_ready)
    else $error("result overwritten before taken");
`endif

endmodule

/* design/crsm_ctrl.sv */
// crsm_ctrl: sequencer for one pair at a time and the end-of-set mean
// drives datapath commands from its status; depends on crsm_pkg
module crsm_ctrl import crsm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t     state_r;
  state_t     state_nxt;
  logic [1:0] ch_r;
  logic [1:0] ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ch_nxt = '0;
        if (sts.capped || sts.ref_zero) begin
          state_nxt = sts.last ? ST_MEAN_GO : ST_IDLE;
        end else begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.unit_done) begin
          if (ch_r == 2'd2) begin
            state_nxt = ST_SUMS;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_SUMS: begin
        ch_nxt    = '0;
        state_nxt = ST_DEV;
      end
      ST_DEV: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (ch_r == 2'd2) begin
          state_nxt = ST_RT_GO;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = ST_DEV;
        end
      end
      ST_RT_GO: state_nxt = ST_RT_WAIT;
      ST_RT_WAIT: begin
        if (sts.unit_done) begin
          state_nxt = ST_SPREAD;
        end
      end
      ST_SPREAD: state_nxt = sts.last ? ST_MEAN_GO : ST_IDLE;
      ST_MEAN_GO: state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (sts.unit_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.uop  = UOP_RATIO;
    cmd.ch   = ch_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK:    cmd.count_inc = !sts.capped;
      ST_DIV_GO:   cmd.unit_start = 1'b1;
      ST_DIV_WAIT: cmd.store_ratio = sts.unit_done;
      ST_SUMS:     cmd.calc_sum = 1'b1;
      ST_DEV:      cmd.dev = 1'b1;
      ST_MUL:      cmd.mul = 1'b1;
      ST_ACC:      cmd.acc = 1'b1;
      ST_RT_GO: begin
        cmd.unit_start = 1'b1;
        cmd.uop        = UOP_ROOT;
      end
      ST_RT_WAIT:  cmd.store_spread = sts.unit_done;
      ST_SPREAD:   cmd.accum = 1'b1;
      ST_MEAN_GO: begin
        cmd.unit_start = 1'b1;
        cmd.uop        = UOP_MEAN;
      end
      ST_MEAN_WAIT: cmd.uop = UOP_MEAN;
      ST_EMIT:     cmd.emit = sts.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

/* design/color_ratio_spread_mean.sv */
// color_ratio_spread_mean: one pixel pair per item, spread sum and mean per set
// a pair with a nonzero reference runs, before ready returns, three 24-step ratio divides
//   and a 26-step root on one shared unit, then root/3 by a constant multiply
// a pair with an all-zero reference, or past the pair limit, skips the ratio and root steps
// a last pair adds the 40-step mean divide and the result load
// one item at a time; a result still held in the output register stalls only
//   the emit of the next set; reset: synchronous active-low rst_n clears the running sum,
//   count, sequencer and result valid
module color_ratio_spread_mean import crsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  crsm_in_if.sink    in_pair,
  crsm_out_if.source out_result
);

  pair_t   pair;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // pack the incoming item for the datapath input register
  assign pair.first_blue   = in_pair.first_blue;
  assign pair.first_green  = in_pair.first_green;
  assign pair.first_red    = in_pair.first_red;
  assign pair.second_blue  = in_pair.second_blue;
  assign pair.second_green = in_pair.second_green;
  assign pair.second_red   = in_pair.second_red;
  assign pair.last_pair    = in_pair.last_pair;

  // sequencer: owns the input handshake and steps the datapath
  crsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pair.valid),
    .in_ready (in_pair.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: ratios, deviations, shared divide/root unit, set sum and output register
  crsm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair      (pair),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_result.ready),
    .out_valid (out_result.valid),
    .out_mean  (out_result.mean_spread),
    .out_count (out_result.pair_count)
  );

endmodule

/* bench/color_ratio_spread_mean_tb.sv */
// color_ratio_spread_mean_tb: self-checking bench for the color ratio spread mean block
// predicts the per-set mean spread and pair count and compares every result item
// depends on crsm_pkg, crsm_in_if, crsm_out_if and color_ratio_spread_mean
`timescale 1ns / 1ps

module color_ratio_spread_mean_tb;
  import crsm_pkg::*;

  // hard stop well beyond the slowest legal run
  localparam int CYCLE_LIMIT   = 4_000_000;
  // pair with a nonzero reference plus the mean divide, with margin
  localparam int LATENCY_SLACK = 250;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int MAX_GAP       = 14;

  typedef struct {
    logic [MEAN_W-1:0]  mean;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  logic clk;
  logic rst_n;

  crsm_in_if  in_pair();
  crsm_out_if out_result();

  color_ratio_spread_mean dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pair    (in_pair),
    .out_result (out_result)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // predictor state: running sum of spreads and pairs counted in the open set
  logic [SUM_W-1:0]   spread_total;
  logic [COUNT_W-1:0] pairs_in_set;
  set_result_t        pending_sets[$];

  int  fail_count  = 0;
  int  cycle_count = 0;
  // per-item random waits on each side, switched off for bursts
  bit  feed_gaps   = 1'b1;
  bit  drain_gaps  = 1'b1;
  // long receiver hold-off, picked up by the ready driver
  int  ready_hold  = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one channel ratio first/second in Q8.16, a zero divisor counts as one
  function automatic logic [RATIO_W-1:0] ratio_q16(logic [PIX_W-1:0] num,
                                                   logic [PIX_W-1:0] den);
    logic [RATIO_W-1:0] den_nz;
    den_nz = (den == '0) ? RATIO_W'(1) : RATIO_W'(den);
    return {num, 16'h0000} / den_nz;
  endfunction

  // floor of the square root, one result bit at a time from the top
  function automatic logic [ROOT_W-1:0] floor_root(logic [63:0] x);
    logic [63:0] trial;
    logic [ROOT_W-1:0] root;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = 64'(root) | (64'd1 << b);
      if (trial * trial <= x) begin
        root = trial[ROOT_W-1:0];
      end
    end
    return root;
  endfunction

  // root of the summed squared deviations of the three ratios from their mean;
  // works in thirds (3*r - S) so everything stays an exact integer until /9
  function automatic logic [ROOT_W-1:0] ratio_spread(pair_t p);
    logic [RATIO_W-1:0] r [3];
    logic [SUMR_W-1:0]  s;
    logic [SUMR_W-1:0]  a;
    logic [SUMR_W-1:0]  d;
    logic [63:0]        t;
    r[0] = ratio_q16(p.first_blue,  p.second_blue);
    r[1] = ratio_q16(p.first_green, p.second_green);
    r[2] = ratio_q16(p.first_red,   p.second_red);
    s = SUMR_W'(r[0]) + SUMR_W'(r[1]) + SUMR_W'(r[2]);
    t = '0;
    for (int i = 0; i < 3; i++) begin
      a = SUMR_W'(3 * r[i]);
      d = (a >= s) ? (a - s) : (s - a);
      t += 64'(d) * 64'(d);
    end
    return floor_root(t / 9);
  endfunction

  // fold one accepted item into the running state, queue a result on a last mark
  task automatic fold_pair(pair_t p);
    logic [SUM_W:0]   widened;
    logic [SUM_W-1:0] quotient;
    set_result_t      res;
    // past the pair limit an item is neither counted nor summed
    if (pairs_in_set < COUNT_CAP) begin
      pairs_in_set++;
      if ({p.second_blue, p.second_green, p.second_red} != '0) begin
        widened = {1'b0, spread_total} + (SUM_W+1)'(ratio_spread(p));
        // sum saturates instead of wrapping
        spread_total = widened[SUM_W] ? '1 : widened[SUM_W-1:0];
      end
    end
    if (p.last_pair) begin
      quotient  = (pairs_in_set != '0) ? spread_total / SUM_W'(pairs_in_set) : '0;
      res.mean  = (quotient > SUM_W'(24'hFFFFFF)) ? '1 : quotient[MEAN_W-1:0];
      res.count = pairs_in_set;
      pending_sets = {pending_sets, res};
      spread_total = '0;
      pairs_in_set = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pair_t make_pair(int fb, int fg, int fr, int sb, int sg, int sr,
                                      bit is_last);
    pair_t p;
    p.first_blue   = PIX_W'(fb);
    p.first_green  = PIX_W'(fg);
    p.first_red    = PIX_W'(fr);
    p.second_blue  = PIX_W'(sb);
    p.second_green = PIX_W'(sg);
    p.second_red   = PIX_W'(sr);
    p.last_pair    = is_last;
    return p;
  endfunction

  // channel value leaning toward the extremes
  function automatic logic [PIX_W-1:0] pick_channel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      return '0;
    end
    if (roll < 20) begin
      return '1;
    end
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // random pair, now and then with an all-zero reference pixel
  function automatic pair_t random_pair(bit is_last);
    pair_t p;
    p.first_blue  = pick_channel();
    p.first_green = pick_channel();
    p.first_red   = pick_channel();
    if ($urandom_range(0, 99) < 8) begin
      p.second_blue  = '0;
      p.second_green = '0;
      p.second_red   = '0;
    end else begin
      p.second_blue  = pick_channel();
      p.second_green = pick_channel();
      p.second_red   = pick_channel();
    end
    p.last_pair = is_last;
    return p;
  endfunction

  // offer one item and hold it until accepted; called on a rising edge and
  // returns on the edge of acceptance with valid still high
  task automatic send_pair(pair_t p);
    int gap;
    gap = feed_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_pair.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pair.first_blue   <= p.first_blue;
    in_pair.first_green  <= p.first_green;
    in_pair.first_red    <= p.first_red;
    in_pair.second_blue  <= p.second_blue;
    in_pair.second_green <= p.second_green;
    in_pair.second_red   <= p.second_red;
    in_pair.last_pair    <= p.last_pair;
    in_pair.valid        <= 1'b1;
    do @(posedge clk); while (!in_pair.ready);
    fold_pair(p);
  endtask

  // a whole set of random pairs, last mark on the final one
  task automatic send_random_set(int len);
    for (int i = 0; i < len; i++) begin
      send_pair(random_pair(i == len - 1));
    end
  endtask

  // sender stops and waits until every queued result has come back
  task automatic wait_drained(int settle);
    in_pair.valid <= 1'b0;
    @(posedge clk);
    while (pending_sets.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // single-pair sets: field extremes, equal ratios, widest spread,
  // all-zero reference, zero reference channels
  task automatic test_single_pairs();
    send_pair(make_pair(255, 255, 255, 255, 255, 255, 1'b1));
    send_pair(make_pair(  0,   0,   0, 255, 255, 255, 1'b1));
    send_pair(make_pair(255,   0,   0,   1,   1,   1, 1'b1));
    send_pair(make_pair(255, 255, 255,   1,   1, 255, 1'b1));
    send_pair(make_pair(255, 255, 255,   0,   0,   0, 1'b1));
    send_pair(make_pair(  0,   0,   0,   0,   0,   0, 1'b1));
    send_pair(make_pair(200,  17,  99,   0,   5,   7, 1'b1));
    send_pair(make_pair(  1, 255,   0,   0,   0, 255, 1'b1));
    send_pair(make_pair(  0, 128, 255, 255,   0,   1, 1'b1));
    wait_drained(4);
  endtask

  // multi-pair sets: skipped pairs still count toward the divisor,
  // and a set may end on a skipped pair
  task automatic test_mixed_sets();
    send_pair(make_pair(255,   0,   0,   1,   1,   1, 1'b0));
    send_pair(make_pair( 90,  90,  90,   0,   0,   0, 1'b0));
    send_pair(make_pair( 13, 200,  77,   0,  33,   0, 1'b0));
    send_pair(make_pair(100,  50,  25,  10,  20,  40, 1'b0));
    send_pair(make_pair(255, 255, 255,   0,   0,   0, 1'b0));
    send_pair(make_pair(  7, 250, 128,   3, 255,  64, 1'b1));
    send_pair(make_pair(255,   1, 128,   2,   2,   2, 1'b0));
    send_pair(make_pair( 40,  80, 160,   5,   5,   5, 1'b0));
    send_pair(make_pair(  9,   9,   9,   0,   0,   0, 1'b1));
    wait_drained(4);
  endtask

  // receiver stalls for a long stretch while short sets keep coming, so the
  // result slot fills and the block has to hold off its input
  task automatic test_result_backpressure();
    pair_t p;
    ready_hold = 1500;
    for (int s = 0; s < 12; s++) begin
      if ($urandom_range(0, 1) == 1) begin
        p = random_pair(1'b0);
        p.second_blue = '0;
        p.second_green = '0;
        p.second_red = '0;
        send_pair(p);
      end
      p = random_pair(1'b1);
      if ($urandom_range(0, 99) < 80) begin
        p.second_blue = '0;
        p.second_green = '0;
        p.second_red = '0;
      end
      send_pair(p);
    end
    // sender pauses until every result is back
    wait_drained(4);
  endtask

  // random sets of mostly short length, idling mode switched now and then
  task automatic test_random_sets();
    int sent;
    int len;
    int roll;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        len = $urandom_range(1, 6);
      end else if (roll < 95) begin
        len = $urandom_range(7, 30);
      end else begin
        len = $urandom_range(31, 120);
      end
      // occasional bursts with one or both sides never idling
      if ($urandom_range(0, 9) == 0) begin
        feed_gaps  = 1'($urandom_range(0, 1));
        drain_gaps = 1'($urandom_range(0, 1));
      end
      send_random_set(len);
      sent += len;
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drained(4);
        paused = 1'b1;
      end
    end
    feed_gaps  = 1'b1;
    drain_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready driver and checker
  // ---------------------------------------------------------------------------

  // ready is drawn per result item; a requested hold-off overrides the draw
  initial begin : result_ready_driver
    int gap;
    out_result.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = drain_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (ready_hold > 0) begin
        gap        = ready_hold;
        ready_hold = 0;
      end
      if (gap > 0) begin
        out_result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_result.ready <= 1'b1;
      // stay ready until an item moves or a hold-off is asked for
      do @(posedge clk);
      while (!(out_result.valid && out_result.ready) && ready_hold == 0);
    end
  end

  // every result item is compared with the oldest predicted set
  always @(posedge clk) begin : result_check
    set_result_t want;
    if (rst_n && out_result.valid && out_result.ready) begin
      if (pending_sets.size() == 0) begin
        $error("unexpected result item: mean_spread %0d, pair_count %0d",
               out_result.mean_spread, out_result.pair_count);
        fail_count++;
      end else begin
        want = pending_sets.pop_front();
        if (out_result.mean_spread !== want.mean) begin
          $error("mean_spread: expected %0d, got %0d", want.mean, out_result.mean_spread);
          fail_count++;
        end
        if (out_result.pair_count !== want.count) begin
          $error("pair_count: expected %0d, got %0d", want.count, out_result.pair_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                <= 1'b0;
    in_pair.valid        <= 1'b0;
    in_pair.first_blue   <= '0;
    in_pair.first_green  <= '0;
    in_pair.first_red    <= '0;
    in_pair.second_blue  <= '0;
    in_pair.second_green <= '0;
    in_pair.second_red   <= '0;
    in_pair.last_pair    <= 1'b0;
    spread_total = '0;
    pairs_in_set = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_pairs();
    test_mixed_sets();
    test_result_backpressure();
    test_random_sets();
    // a short closing set after the random run
    send_random_set(5);

    // let the last results drain and watch for stray items
    wait_drained(LATENCY_SLACK);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* color_ratio_spread_mean.f */
design/crsm_pkg.sv
design/crsm_if.sv
design/crsm_divroot.sv
design/crsm_datapath.sv
design/crsm_ctrl.sv
design/color_ratio_spread_mean.sv
bench/color_ratio_spread_mean_tb.sv
